### rtl/pal_pkg.sv
// Shared types and constants for the pooled adjacency list manager.
`timescale 1ns / 1ps

package pal_pkg;

  // Fixed field widths of the stream payloads and the configuration register.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned NODE_W   = 10;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DEGREE_W = 13;
  localparam int unsigned NCNT_W   = 11;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [NCNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

  // Command codes carried by the input transfer.
  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_EXISTS   = 2'd2,
    CMD_DEGREE   = 2'd3
  } cmd_e;

  // Status codes carried by the result transfer.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_POOL_FULL = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Source of the entry memory read address.
  typedef enum logic [1:0] {
    RD_FREE   = 2'd0,
    RD_CURSOR = 2'd1,
    RD_HEAD   = 2'd2,
    RD_NEXT   = 2'd3
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    rd_in_node;
    rd_sel_e rd_sel;
    logic    ptr_from_head;
    logic    advance;
    logic    reg_commit;
    logic    unlink;
    logic    free_commit;
    logic    set_status;
    status_e status;
    logic    set_found;
    logic    out_load;
  } pal_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic bad_node;
    logic free_empty;
    logic head_null;
    logic next_null;
    logic hit;
    cmd_e cmd;
  } pal_sts_t;

endpackage

### rtl/pal_datapath.sv
// Datapath: list memories, free list head, walk cursor and result registers.
`timescale 1ns / 1ps

module pal_datapath import pal_pkg::*; #(
  parameter int unsigned NODES   = 1024,
  parameter int unsigned ENTRIES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pal_ctl_t            ctl_i,
  output pal_sts_t            sts_o,
  input  cmd_e                in_cmd_i,
  input  logic [NODE_W-1:0]   in_node_i,
  input  logic [ITEM_W-1:0]   in_item_i,
  input  logic                cfg_valid_i,
  input  logic [NCNT_W-1:0]   cfg_data_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic                out_found_o,
  output logic [DEGREE_W-1:0] out_degree_o
);

  localparam int unsigned PW      = $clog2(ENTRIES + 1);
  localparam int unsigned EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned HW      = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CLR_LEN = (NODES > ENTRIES) ? NODES : ENTRIES;
  localparam int unsigned CLRW    = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;
  localparam logic [PW-1:0]   NULL_PTR = PW'(ENTRIES);
  localparam logic [CLRW-1:0] CLR_LAST = CLRW'(CLR_LEN - 1);

  // Memories.
  logic [PW-1:0]     list_head_mem  [NODES];
  logic [PW-1:0]     entry_next_mem [ENTRIES];
  logic [ITEM_W-1:0] entry_item_mem [ENTRIES];

  // Registers.
  logic [NCNT_W-1:0] node_count_q;
  logic [CLRW-1:0]   clr_q, clr_d;
  logic [PW-1:0]     free_head_q, free_head_d;
  logic [PW-1:0]     p_q, p_d;
  logic [PW-1:0]     prev_q, prev_d;
  logic [PW-1:0]     cnt_q, cnt_d;
  cmd_e              cmd_q;
  logic [NODE_W-1:0] node_q;
  logic [ITEM_W-1:0] item_q;
  logic              bad_node_q;
  status_e           status_q;
  logic              found_q;
  logic [PW-1:0]     head_rd_q;
  logic [PW-1:0]     next_rd_q;
  logic [ITEM_W-1:0] item_rd_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_found_q;
  logic [DEGREE_W-1:0] out_degree_q;

  // Address and write port signals.
  logic [31:0]       clr_ext, head_rd_node_ext, node_q_ext, cnt_ext;
  logic [HW-1:0]     head_rd_idx;
  logic [PW-1:0]     entry_rd_ptr;
  logic [EW-1:0]     entry_rd_idx;
  logic              head_we;
  logic [HW-1:0]     head_wa;
  logic [PW-1:0]     head_wd;
  logic              next_we;
  logic [EW-1:0]     next_wa;
  logic [PW-1:0]     next_wd;
  logic              item_we;
  logic [EW-1:0]     item_wa;
  logic              in_bad;
  logic              prev_null;
  logic [31:0]       clr_inc;

  assign clr_ext    = 32'(clr_q);
  assign clr_inc    = clr_ext + 32'd1;
  assign node_q_ext = 32'(node_q);
  assign cnt_ext    = 32'(cnt_q);
  assign prev_null  = (prev_q == NULL_PTR);

  // Range check of the incoming node against the configured count and the pool size.
  assign in_bad = ({1'b0, in_node_i} >= node_count_q) || (32'(in_node_i) >= 32'(NODES));

  // Read address selection.
  assign head_rd_node_ext = ctl_i.rd_in_node ? 32'(in_node_i) : node_q_ext;
  assign head_rd_idx      = head_rd_node_ext[HW-1:0];

  always_comb begin
    case (ctl_i.rd_sel)
      RD_FREE:   entry_rd_ptr = free_head_q;
      RD_HEAD:   entry_rd_ptr = head_rd_q;
      RD_NEXT:   entry_rd_ptr = next_rd_q;
      default:   entry_rd_ptr = p_q;
    endcase
  end
  assign entry_rd_idx = entry_rd_ptr[EW-1:0];

  // Write port selection for the three memories.
  always_comb begin
    head_we = 1'b0;
    head_wa = node_q_ext[HW-1:0];
    head_wd = NULL_PTR;
    next_we = 1'b0;
    next_wa = p_q[EW-1:0];
    next_wd = free_head_q;
    item_we = 1'b0;
    item_wa = free_head_q[EW-1:0];
    if (ctl_i.clr_step) begin
      head_we = (clr_ext < 32'(NODES));
      head_wa = clr_ext[HW-1:0];
      head_wd = NULL_PTR;
      next_we = (clr_ext < 32'(ENTRIES));
      next_wa = clr_ext[EW-1:0];
      next_wd = clr_inc[PW-1:0];
    end else if (ctl_i.reg_commit) begin
      head_we = 1'b1;
      head_wd = free_head_q;
      next_we = 1'b1;
      next_wa = free_head_q[EW-1:0];
      next_wd = head_rd_q;
      item_we = 1'b1;
    end else if (ctl_i.unlink) begin
      if (prev_null) begin
        head_we = 1'b1;
        head_wd = next_rd_q;
      end else begin
        next_we = 1'b1;
        next_wa = prev_q[EW-1:0];
        next_wd = next_rd_q;
      end
    end else if (ctl_i.free_commit) begin
      next_we = 1'b1;
    end
  end

  // Memory writes.
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      list_head_mem[head_wa] <= head_wd;
    end
    if (next_we) begin
      entry_next_mem[next_wa] <= next_wd;
    end
    if (item_we) begin
      entry_item_mem[item_wa] <= item_q;
    end
  end

  // Registered memory reads.
  always_ff @(posedge clk_i) begin
    head_rd_q <= list_head_mem[head_rd_idx];
    next_rd_q <= entry_next_mem[entry_rd_idx];
    item_rd_q <= entry_item_mem[entry_rd_idx];
  end

  // Next values of the pointer registers.
  always_comb begin
    clr_d       = ctl_i.clr_step ? clr_q + CLRW'(1) : clr_q;
    free_head_d = free_head_q;
    if (ctl_i.reg_commit) begin
      free_head_d = next_rd_q;
    end else if (ctl_i.free_commit) begin
      free_head_d = p_q;
    end
    p_d    = p_q;
    prev_d = prev_q;
    cnt_d  = cnt_q;
    if (ctl_i.load) begin
      cnt_d = '0;
    end else if (ctl_i.ptr_from_head) begin
      p_d    = head_rd_q;
      prev_d = NULL_PTR;
      cnt_d  = '0;
    end else if (ctl_i.advance) begin
      p_d    = next_rd_q;
      prev_d = p_q;
      cnt_d  = cnt_q + PW'(1);
    end
  end

  // Control registers with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RESET;
      clr_q        <= '0;
      free_head_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        node_count_q <= cfg_data_i;
      end
      clr_q       <= clr_d;
      free_head_q <= free_head_d;
    end
  end

  // Payload registers: command capture, cursor and result.
  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    prev_q <= prev_d;
    cnt_q  <= cnt_d;
    if (ctl_i.load) begin
      cmd_q      <= in_cmd_i;
      node_q     <= in_node_i;
      item_q     <= in_item_i;
      bad_node_q <= in_bad;
      status_q   <= ST_OK;
      found_q    <= 1'b0;
    end else begin
      if (ctl_i.set_status) begin
        status_q <= ctl_i.status;
      end
      if (ctl_i.set_found) begin
        found_q <= 1'b1;
      end
    end
    if (ctl_i.out_load) begin
      out_status_q <= status_q;
      out_found_q  <= found_q;
      out_degree_q <= (cmd_q == CMD_DEGREE) ? cnt_ext[DEGREE_W-1:0] : '0;
    end
  end

  assign out_status_o = out_status_q;
  assign out_found_o  = out_found_q;
  assign out_degree_o = out_degree_q;

  // Status toward the controller.
  assign sts_o.clr_last   = (clr_q == CLR_LAST);
  assign sts_o.bad_node   = bad_node_q;
  assign sts_o.free_empty = (free_head_q == NULL_PTR);
  assign sts_o.head_null  = (head_rd_q == NULL_PTR);
  assign sts_o.next_null  = (next_rd_q == NULL_PTR);
  assign sts_o.hit        = (item_rd_q == item_q);
  assign sts_o.cmd        = cmd_q;

endmodule

### rtl/pal_ctrl.sv
// Controller: sequences the clearing pass, list walks and result handoff.
`timescale 1ns / 1ps

module pal_ctrl import pal_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  pal_sts_t sts_i,
  output pal_ctl_t ctl_o
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FIRST  = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_UNLINK = 3'd4;
  localparam logic [2:0] S_FREE   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.rd_sel = RD_CURSOR;
    ctl_o.status = ST_OK;
    case (state_q)
      S_INIT: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ctl_o.rd_in_node = 1'b1;
        ctl_o.rd_sel     = RD_FREE;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_FIRST;
        end
      end
      S_FIRST: begin
        state_d = S_DONE;
        if (sts_i.bad_node) begin
          ctl_o.set_status = 1'b1;
          ctl_o.status     = ST_RANGE;
        end else if (sts_i.cmd == CMD_REGISTER) begin
          if (sts_i.free_empty) begin
            ctl_o.set_status = 1'b1;
            ctl_o.status     = ST_POOL_FULL;
          end else begin
            ctl_o.reg_commit = 1'b1;
          end
        end else begin
          ctl_o.ptr_from_head = 1'b1;
          ctl_o.rd_sel        = RD_HEAD;
          if (!sts_i.head_null) begin
            state_d = S_CMP;
          end else if (sts_i.cmd == CMD_REMOVE) begin
            ctl_o.set_status = 1'b1;
            ctl_o.status     = ST_NOT_FOUND;
          end
        end
      end
      S_CMP: begin
        if (sts_i.cmd != CMD_DEGREE && sts_i.hit) begin
          if (sts_i.cmd == CMD_EXISTS) begin
            ctl_o.set_found = 1'b1;
            state_d         = S_DONE;
          end else begin
            state_d = S_UNLINK;
          end
        end else begin
          ctl_o.advance = 1'b1;
          ctl_o.rd_sel  = RD_NEXT;
          if (sts_i.next_null) begin
            state_d = S_DONE;
            if (sts_i.cmd == CMD_REMOVE) begin
              ctl_o.set_status = 1'b1;
              ctl_o.status     = ST_NOT_FOUND;
            end
          end
        end
      end
      S_UNLINK: begin
        ctl_o.unlink = 1'b1;
        state_d      = S_FREE;
      end
      S_FREE: begin
        ctl_o.free_commit = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/pooled_adjacency_list_manager_unit.sv
// Top level of the pooled adjacency list manager.
//
// Channel   Direction  Width  Contents
// s_axis    in         48     command, node, item
// m_axis    out        16     status, found, degree
// cfg       in         11     node_count
//
// A register command passes from input transfer through states FIRST and DONE to the
// output register. Exists, degree and remove walk the list after FIRST, visiting entries
// one per cycle through the entry memory read port; a remove that finds its item adds
// the unlink and free-list write states; both can use the entry link memory's write port.
// After reset a clearing pass initializes the list heads and the free-list chain; no
// input transfer is taken during it, configuration writes are.
// A result waits in the output register while the next input transfer is taken.
`timescale 1ns / 1ps

module pooled_adjacency_list_manager_unit import pal_pkg::*; #(
  parameter int unsigned NODES   = 1024,
  parameter int unsigned ENTRIES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [1:0] command, [11:2] node, [43:12] item, [47:44] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [1:0] status, [2] found, [15:3] degree
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [NCNT_W-1:0]     cfg_data_i
);

  pal_ctl_t            ctl;
  pal_sts_t            sts;
  cmd_e                in_cmd;
  logic [STATUS_W-1:0] out_status;
  logic                out_found;
  logic [DEGREE_W-1:0] out_degree;

  // Input payload unpacking.
  assign in_cmd = cmd_e'(s_tdata[1:0]);

  // User writes configuration only while idle (not enforced); the port always takes them.
  assign cfg_ready_o = 1'b1;

  pal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  pal_datapath #(
    .NODES   (NODES),
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .in_cmd_i     (in_cmd),
    .in_node_i    (s_tdata[11:2]),
    .in_item_i    (s_tdata[43:12]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_status_o (out_status),
    .out_found_o  (out_found),
    .out_degree_o (out_degree)
  );

  // Result payload packing.
  assign m_tdata = {out_degree, out_found, out_status};

endmodule

### verif/pooled_adjacency_list_manager_unit_test.sv
// Self-checking testbench for the pooled adjacency list manager: random and directed commands.
`timescale 1ns / 1ps

module pooled_adjacency_list_manager_unit_test;
  import pal_pkg::*;

  localparam int unsigned NODES          = 1024;
  localparam int unsigned ENTRIES        = 4096;
  localparam logic [12:0] NULL_LINK      = 13'(ENTRIES);
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    cmd_e        op;
    logic [9:0]  node;
    logic [31:0] item;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic        found;
    logic [12:0] degree;
  } reply_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  s_tvalid    = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata     = '0;
  logic                  m_tvalid;
  logic                  m_tready    = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [NCNT_W-1:0]     cfg_data_i  = '0;

  // Shadow copy of the block's lists, pool and node count.
  logic [12:0]       head_ptr   [NODES];
  logic [12:0]       link_ptr   [ENTRIES];
  logic [31:0]       slot_value [ENTRIES];
  logic [12:0]       free_ptr;
  logic [NCNT_W-1:0] node_limit;

  request_t    pending_requests[$];
  reply_t      awaited_replies[$];
  request_t    on_bus;
  logic [31:0] item_choices[8];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned stall_cycles  = 0;

  pooled_adjacency_list_manager_unit #(
    .NODES  (NODES),
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Clock generation.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Apply one command to the shadow lists and return the reply it should produce.
  function automatic reply_t apply_request(request_t r);
    reply_t      rep;
    logic [12:0] p;
    logic [12:0] prev;
    int unsigned steps;
    rep.status = ST_OK;
    rep.found  = 1'b0;
    rep.degree = '0;
    if ({1'b0, r.node} >= node_limit) begin
      rep.status = ST_RANGE;
    end else if (r.op == CMD_REGISTER) begin
      if (free_ptr >= NULL_LINK) begin
        rep.status = ST_POOL_FULL;
      end else begin
        p                = free_ptr;
        free_ptr         = link_ptr[p];
        link_ptr[p]      = head_ptr[r.node];
        head_ptr[r.node] = p;
        slot_value[p]    = r.item;
      end
    end else begin
      // Walk the list; degree counts every entry, the others stop at the first match.
      p     = head_ptr[r.node];
      prev  = NULL_LINK;
      steps = 0;
      while (p < NULL_LINK && steps < ENTRIES) begin
        if (r.op != CMD_DEGREE && slot_value[p] == r.item) break;
        prev = p;
        p    = link_ptr[p];
        steps++;
      end
      if (r.op == CMD_DEGREE) begin
        rep.degree = 13'(steps);
      end else if (r.op == CMD_EXISTS) begin
        rep.found = (p < NULL_LINK && steps < ENTRIES);
      end else if (!(p < NULL_LINK && steps < ENTRIES)) begin
        rep.status = ST_NOT_FOUND;
      end else begin
        if (prev < NULL_LINK) begin
          link_ptr[prev] = link_ptr[p];
        end else begin
          head_ptr[r.node] = link_ptr[p];
        end
        link_ptr[p] = free_ptr;
        free_ptr    = p;
      end
    end
    return rep;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // Mostly values from a small set so that lookups hit, the rest fully random.
  function automatic logic [31:0] pick_item();
    if ($urandom_range(0, 9) < 7) begin
      return item_choices[$urandom_range(0, 7)];
    end
    return $urandom();
  endfunction

  function automatic request_t make_request(int unsigned node_hi, int unsigned reg_pct);
    request_t r;
    if ($urandom_range(0, 99) < reg_pct) begin
      r.op = CMD_REGISTER;
    end else begin
      r.op = cmd_e'($urandom_range(1, 3));
    end
    if ($urandom_range(0, 99) < 18) begin
      r.node = 10'($urandom_range(0, NODES - 1));
    end else begin
      r.node = 10'($urandom_range(0, node_hi));
    end
    r.item = pick_item();
    return r;
  endfunction

  function automatic void queue_request(cmd_e op, int unsigned node, logic [31:0] item);
    request_t r;
    r.op   = op;
    r.node = 10'(node);
    r.item = item;
    pending_requests.push_back(r);
  endfunction

  function automatic void queue_random(int unsigned count, int unsigned node_hi,
                                       int unsigned reg_pct);
    for (int unsigned i = 0; i < count; i++) begin
      pending_requests.push_back(make_request(node_hi, reg_pct));
    end
  endfunction

  // Command driver: presents queued requests and predicts each one as its transfer completes.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_replies.push_back(apply_request(on_bus));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {4'b0, on_bus.item, on_bus.node, on_bus.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor: random back-pressure and field-by-field comparison.
  always @(posedge clk_i) begin
    reply_t want;
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst_ni && m_tvalid && m_tready) begin
      if (awaited_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reply, expected none, got %h", $time, m_tdata);
      end else begin
        want = awaited_replies.pop_front();
        check_field("status", want.status, m_tdata[1:0]);
        check_field("found", want.found, m_tdata[2]);
        check_field("degree", want.degree, m_tdata[15:3]);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_node_count(logic [NCNT_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    node_limit = value;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || s_tvalid || awaited_replies.size() != 0);
  endtask

  // Test sequence.
  initial begin
    for (int unsigned i = 0; i < NODES; i++) head_ptr[i] = NULL_LINK;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      link_ptr[i]   = 13'(i + 1);
      slot_value[i] = '0;
    end
    free_ptr   = '0;
    node_limit = NODE_COUNT_RESET;
    item_choices[0] = 32'h0000_0000;
    item_choices[1] = 32'hFFFF_FFFF;
    for (int unsigned i = 2; i < 8; i++) item_choices[i] = $urandom();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full node range; sender idles lightly, receiver heavily.
    send_idle_pct = 26;
    recv_idle_pct = 73;
    write_node_count(11'd1024);
    queue_request(CMD_DEGREE, 0, 32'h0);
    queue_request(CMD_EXISTS, 0, 32'h0);
    queue_request(CMD_REMOVE, 0, 32'h0);
    queue_request(CMD_REGISTER, 0, 32'h0000_0000);
    queue_request(CMD_REGISTER, 0, 32'hFFFF_FFFF);
    queue_request(CMD_REGISTER, 1023, 32'h1234_5678);
    queue_request(CMD_REGISTER, 0, 32'h0000_0000);
    queue_request(CMD_DEGREE, 0, 32'h0);
    queue_request(CMD_EXISTS, 0, 32'hFFFF_FFFF);
    queue_request(CMD_EXISTS, 0, 32'h0000_0005);
    // Duplicate values: remove takes the most recent one first.
    queue_request(CMD_REMOVE, 0, 32'h0000_0000);
    queue_request(CMD_DEGREE, 0, 32'h0);
    queue_request(CMD_REMOVE, 0, 32'hFFFF_FFFF);
    queue_request(CMD_REMOVE, 0, 32'h0000_0000);
    queue_request(CMD_REMOVE, 0, 32'h0000_0000);
    queue_request(CMD_DEGREE, 0, 32'h0);
    queue_request(CMD_DEGREE, 1023, 32'h0);
    queue_request(CMD_EXISTS, 1023, 32'h1234_5678);
    queue_request(CMD_REMOVE, 1023, 32'h1234_5678);
    queue_request(CMD_EXISTS, 1023, 32'h1234_5678);
    queue_random(170, 15, 40);
    wait_drained();

    // Single node: everything above node zero is out of range.
    send_idle_pct = 73;
    recv_idle_pct = 26;
    write_node_count(11'd1);
    queue_request(CMD_REGISTER, 1, 32'hA5A5_A5A5);
    queue_request(CMD_REMOVE, 1023, 32'h0);
    queue_request(CMD_EXISTS, 512, 32'h0);
    queue_request(CMD_DEGREE, 1, 32'h0);
    queue_random(70, 1, 40);
    wait_drained();

    // A node count of zero rejects every node.
    write_node_count(11'd0);
    queue_request(CMD_REGISTER, 0, 32'h0);
    queue_request(CMD_REMOVE, 0, 32'h0);
    queue_request(CMD_EXISTS, 0, 32'h0);
    queue_request(CMD_DEGREE, 0, 32'h0);
    queue_random(8, 3, 25);
    wait_drained();

    write_node_count(11'd37);
    queue_random(120, 40, 35);
    wait_drained();

    // No idling: load a spread of nodes back to back, then query and churn them.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_node_count(11'd1024);
    for (int unsigned i = 0; i < 64; i++) begin
      queue_request(CMD_REGISTER, i % 16, pick_item());
    end
    for (int unsigned i = 0; i < 4; i++) begin
      queue_request(CMD_DEGREE, i, 32'h0);
      queue_request(CMD_EXISTS, i, item_choices[i]);
      queue_request(CMD_REMOVE, i, item_choices[i]);
      queue_request(CMD_REGISTER, 200 + i, $urandom());
    end
    queue_random(60, 127, 20);
    wait_drained();

    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
